/* hdl/mmde_pkg.sv */
// ---------------------------------------------------------------------------
// mmde_pkg
// Shared types and constants for the matrix multiply dot engine: field
// widths, mode and register codes, controller states and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
package mmde_pkg;

    localparam int MODE_W    = 2;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = 36;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_N  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_M  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET_VAL = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_a;       // store incoming element into A
        logic wr_b;       // store incoming element into B
        logic req_start;  // latch request indices, clear accumulator
        logic rd_en;      // issue one inner-product read at k, advance k
        logic out_load;   // move accumulator into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic a_ok;       // incoming A load lies within bounds
        logic b_ok;       // incoming B load lies within bounds
        logic req_err;    // incoming request row/col out of range
        logic k_zero;     // inner length is zero
        logic k_last;     // current k is the last inner index
        logic pipe_busy;  // read or multiply still in flight
        logic out_free;   // output register can take a result this cycle
    } t_dp_status;

endpackage

/* hdl/mmde_ctrl.sv */
// ---------------------------------------------------------------------------
// mmde_ctrl
// Controller for the dot engine: accepts one request at a time, steps the
// datapath through the inner loop, drains the pipeline and hands the
// result to the output register.
// ---------------------------------------------------------------------------
module mmde_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [mmde_pkg::MODE_W-1:0]  i_mode,
    input  mmde_pkg::t_dp_status         i_status,
    output logic                         o_stall,
    output mmde_pkg::t_dp_cmd            o_cmd
);

    mmde_pkg::t_state r_state;
    mmde_pkg::t_state n_state;
    logic             w_accept;

    assign o_stall  = (r_state != mmde_pkg::S_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmde_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmde_pkg::S_IDLE: begin
                if (w_accept && (i_mode == mmde_pkg::MODE_REQUEST)) begin
                    if (i_status.req_err || i_status.k_zero) begin
                        n_state = mmde_pkg::S_DONE;
                    end else begin
                        n_state = mmde_pkg::S_RUN;
                    end
                end
            end
            mmde_pkg::S_RUN: begin
                if (i_status.k_last) begin
                    n_state = mmde_pkg::S_DRAIN;
                end
            end
            mmde_pkg::S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = mmde_pkg::S_DONE;
                end
            end
            mmde_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = mmde_pkg::S_IDLE;
                end
            end
            default: n_state = mmde_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            mmde_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode)
                        mmde_pkg::MODE_LOAD_A:  o_cmd.wr_a      = i_status.a_ok;
                        mmde_pkg::MODE_LOAD_B:  o_cmd.wr_b      = i_status.b_ok;
                        mmde_pkg::MODE_REQUEST: o_cmd.req_start = 1'b1;
                        default: ;  // unused mode, dropped
                    endcase
                end
            end
            mmde_pkg::S_RUN:   o_cmd.rd_en    = 1'b1;
            mmde_pkg::S_DRAIN: ;
            mmde_pkg::S_DONE:  o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/mmde_datapath.sv */
// ---------------------------------------------------------------------------
// mmde_datapath
// Size registers, the A and B element memories, the read / multiply /
// accumulate pipeline and the output register.
// ---------------------------------------------------------------------------
module mmde_datapath #(
    parameter int MAX_DIM = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [mmde_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mmde_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [mmde_pkg::IDX_W-1:0]          i_row,
    input  logic [mmde_pkg::IDX_W-1:0]          i_col,
    input  logic signed [mmde_pkg::VAL_W-1:0]   i_value,
    input  logic                                i_stall,
    input  mmde_pkg::t_dp_cmd                   i_cmd,
    output mmde_pkg::t_dp_status                o_status,
    output logic                                o_valid,
    output logic signed [mmde_pkg::SUM_W-1:0]   o_product_sum,
    output logic                                o_index_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = ($clog2(MAX_DIM + 1) > mmde_pkg::CFG_W) ?
                           $clog2(MAX_DIM + 1) : mmde_pkg::CFG_W;
    localparam int LW    = AW + BW;
    localparam int EXT_W = mmde_pkg::SUM_W - mmde_pkg::PROD_W;

    function automatic logic [BW-1:0] bound_of(input logic [mmde_pkg::CFG_W-1:0] cfg_v);
        logic [BW-1:0] v;
        v = BW'(cfg_v);
        return (v > BW'(MAX_DIM)) ? BW'(MAX_DIM) : v;
    endfunction

    logic [mmde_pkg::CFG_W-1:0]        r_rows;
    logic [mmde_pkg::CFG_W-1:0]        r_inner;
    logic [mmde_pkg::CFG_W-1:0]        r_cols;

    logic signed [mmde_pkg::VAL_W-1:0] r_mem_a [DEPTH];
    logic signed [mmde_pkg::VAL_W-1:0] r_mem_b [DEPTH];

    logic [mmde_pkg::IDX_W-1:0]        r_row;
    logic [mmde_pkg::IDX_W-1:0]        r_col;
    logic [BW-1:0]                     r_k;
    logic                              r_err;
    logic                              r_rd_v;
    logic                              r_mul_v;
    logic signed [mmde_pkg::VAL_W-1:0] r_rd_a;
    logic signed [mmde_pkg::VAL_W-1:0] r_rd_b;
    logic signed [mmde_pkg::PROD_W-1:0] r_prod;
    logic signed [mmde_pkg::SUM_W-1:0] r_acc;
    logic                              r_out_valid;
    logic signed [mmde_pkg::SUM_W-1:0] r_out_sum;
    logic                              r_out_err;

    logic [BW-1:0] w_nb;
    logic [BW-1:0] w_kb;
    logic [BW-1:0] w_mb;
    logic [BW-1:0] w_row;
    logic [BW-1:0] w_col;
    logic [LW-1:0] w_wr_addr;
    logic [LW-1:0] w_rda_addr;
    logic [LW-1:0] w_rdb_addr;
    logic          w_take;

    assign w_nb  = bound_of(r_rows);
    assign w_kb  = bound_of(r_inner);
    assign w_mb  = bound_of(r_cols);
    assign w_row = BW'(i_row);
    assign w_col = BW'(i_col);

    // row-major, MAX_DIM entries per row
    assign w_wr_addr  = LW'(i_row) * LW'(MAX_DIM) + LW'(i_col);
    assign w_rda_addr = LW'(r_row) * LW'(MAX_DIM) + LW'(r_k);
    assign w_rdb_addr = LW'(r_k) * LW'(MAX_DIM) + LW'(r_col);

    assign w_take = r_out_valid && !i_stall;

    assign o_status.a_ok      = (w_row < w_nb) && (w_col < w_kb);
    assign o_status.b_ok      = (w_row < w_kb) && (w_col < w_mb);
    assign o_status.req_err   = (w_row >= w_nb) || (w_col >= w_mb);
    assign o_status.k_zero    = (w_kb == '0);
    assign o_status.k_last    = (r_k == (w_kb - BW'(1)));
    assign o_status.pipe_busy = r_rd_v || r_mul_v;
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_product_sum = r_out_sum;
    assign o_index_error = r_out_err;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= mmde_pkg::CFG_RESET_VAL;
            r_inner <= mmde_pkg::CFG_RESET_VAL;
            r_cols  <= mmde_pkg::CFG_RESET_VAL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mmde_pkg::CFG_ROWS_N:  r_rows  <= i_cfg_data;
                mmde_pkg::CFG_INNER_K: r_inner <= i_cfg_data;
                mmde_pkg::CFG_COLS_M:  r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // element memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[w_wr_addr[AW-1:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_mem_b[w_wr_addr[AW-1:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem_a[w_rda_addr[AW-1:0]];
            r_rd_b <= r_mem_b[w_rdb_addr[AW-1:0]];
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.rd_en;
            r_mul_v <= r_rd_v;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload, multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_start) begin
            r_row <= i_row;
            r_col <= i_col;
            r_err <= o_status.req_err;
            r_k   <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.rd_en) begin
                r_k <= r_k + BW'(1);
            end
            if (r_mul_v) begin
                r_acc <= r_acc + {{EXT_W{r_prod[mmde_pkg::PROD_W-1]}}, r_prod};
            end
        end
        if (r_rd_v) begin
            r_prod <= r_rd_a * r_rd_b;
        end
        if (i_cmd.out_load) begin
            // an out-of-range request never accumulates, so the sum stays zero
            r_out_sum <= r_acc;
            r_out_err <= r_err;
        end
    end

endmodule

/* hdl/matrix_multiply_dot_engine.sv */
// ---------------------------------------------------------------------------
// matrix_multiply_dot_engine
// Element-wise loader and dot-product engine for C = A x B on signed
// 16-bit fixed-point operands with an exact 36-bit sum.
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_mode i_row i_col i_value
//  result    out        o_valid / i_stall          o_product_sum o_index_error
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// A request runs one multiply-accumulate per cycle through a single read
// port on each element memory, then drains the read and multiply stages
// and does the hand-off. Out-of-range requests go straight to the hand-off.
// Reset is synchronous, active low; the element memories are not cleared.
// A result held by i_stall does not block loads; a following request waits
// at the hand-off until the output register frees up.
// ---------------------------------------------------------------------------
module matrix_multiply_dot_engine #(
    parameter int MAX_DIM = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mmde_pkg::MODE_W-1:0]         i_mode,
    input  logic [mmde_pkg::IDX_W-1:0]          i_row,
    input  logic [mmde_pkg::IDX_W-1:0]          i_col,
    input  logic signed [mmde_pkg::VAL_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mmde_pkg::SUM_W-1:0]   o_product_sum,
    output logic                                o_index_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mmde_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mmde_pkg::CFG_W-1:0]          i_cfg_data
);

    mmde_pkg::t_dp_cmd    w_cmd;
    mmde_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    mmde_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    mmde_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_product_sum (o_product_sum),
        .o_index_error (o_index_error)
    );

`ifndef SYNTHESIS
    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("result appeared without a hand-off");

    a_error_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |-> (o_product_sum == '0))
        else $error("out-of-range request returned a nonzero sum");

    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_status.pipe_busy)
        else $error("hand-off while products still in flight");

    a_read_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> o_stall)
        else $error("inner-loop read while input open");
`endif

endmodule
